/* design/mqr_pkg.sv */
// Shared types, constants and the answer byte table of the mDNS A query responder.
// Used by mqr_parser and mqr_answer_gen.
package mqr_pkg;

  typedef enum logic [1:0] {
    PH_HEADER,
    PH_NAME,
    PH_TAIL,
    PH_IGNORE
  } phase_e;

  localparam int unsigned HOST_NAME_LEN = 12;
  localparam int unsigned HEAD_LEN      = 12;
  localparam int unsigned REST_LEN      = 10;
  localparam int unsigned ANSWER_LEN    = 38;

  localparam int unsigned NAME_POS_W = $clog2(HOST_NAME_LEN + 1);
  localparam int unsigned ANS_IDX_W  = $clog2(ANSWER_LEN);

  localparam logic [3:0] HDR_FLAGS_POS = 4'd2;
  localparam logic [3:0] HDR_QDHI_POS  = 4'd4;
  localparam logic [3:0] HDR_QDLO_POS  = 4'd5;
  localparam logic [3:0] HDR_LAST_POS  = 4'd11;

  localparam logic [7:0] ASCII_UPPER_A = 8'h41;
  localparam logic [7:0] ASCII_UPPER_Z = 8'h5A;
  localparam logic [7:0] ASCII_CASE    = 8'h20;

  localparam logic [14:0] QCLASS_IN  = 15'd1;
  localparam logic [15:0] QTYPE_A    = 16'd1;
  localparam logic [15:0] QTYPE_ANY  = 16'd255;

  // Wire-format host name: 4-byte label, 5-byte label "local", root.
  localparam logic [7:0] HOST_NAME [HOST_NAME_LEN] = '{
    8'h04, 8'h6D, 8'h61, 8'h7A, 8'h75,
    8'h05, 8'h6C, 8'h6F, 8'h63, 8'h61, 8'h6C, 8'h00
  };

  // Header: id 0, flags QR|AA, no questions, one answer.
  localparam logic [7:0] ANS_HEAD [HEAD_LEN] = '{
    8'h00, 8'h00, 8'h84, 8'h00, 8'h00, 8'h00,
    8'h00, 8'h01, 8'h00, 8'h00, 8'h00, 8'h00
  };

  // Type A, class IN with cache flush, TTL 120, rdlength 4.
  localparam logic [7:0] ANS_REST [REST_LEN] = '{
    8'h00, 8'h01, 8'h80, 8'h01, 8'h00, 8'h00, 8'h00, 8'h78, 8'h00, 8'h04
  };

  localparam logic [ANS_IDX_W-1:0] NAME_BASE = ANS_IDX_W'(HEAD_LEN);
  localparam logic [ANS_IDX_W-1:0] REST_BASE = ANS_IDX_W'(HEAD_LEN + HOST_NAME_LEN);
  localparam logic [ANS_IDX_W-1:0] ADDR_BASE =
    ANS_IDX_W'(HEAD_LEN + HOST_NAME_LEN + REST_LEN);
  localparam logic [ANS_IDX_W-1:0] ANS_LAST_IDX = ANS_IDX_W'(ANSWER_LEN - 1);

  function automatic logic [7:0] answer_byte(input logic [ANS_IDX_W-1:0] idx,
                                             input logic [31:0] ipv4);
    logic [ANS_IDX_W-1:0] off;
    logic [7:0] res;
    off = '0;
    if (idx < NAME_BASE) begin
      res = ANS_HEAD[idx[3:0]];
    end else if (idx < REST_BASE) begin
      off = idx - NAME_BASE;
      res = HOST_NAME[off[3:0]];
    end else if (idx < ADDR_BASE) begin
      off = idx - REST_BASE;
      res = ANS_REST[off[3:0]];
    end else begin
      off = idx - ADDR_BASE;
      case (off[1:0])
        2'd0:    res = ipv4[31:24];
        2'd1:    res = ipv4[23:16];
        2'd2:    res = ipv4[15:8];
        default: res = ipv4[7:0];
      endcase
    end
    return res;
  endfunction

endpackage

/* design/mqr_parser.sv */
// Payload parser: header checks, question walk, name/type/class match.
// Depends on mqr_pkg; pulses match_o on the byte that completes a matching question.
module mqr_parser (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       accept_i,
  input  logic [7:0] byte_i,
  input  logic       last_i,
  output logic       match_o
);

  mqr_pkg::phase_e phase_q, phase_d;
  logic [3:0]  hdr_pos_q, hdr_pos_d;
  logic [7:0]  flags_q, flags_d;
  logic [15:0] qcount_q, qcount_d;
  logic [5:0]  label_left_q, label_left_d;
  logic [mqr_pkg::NAME_POS_W-1:0] name_pos_q, name_pos_d;
  logic        name_ok_q, name_ok_d;
  logic [1:0]  tail_pos_q, tail_pos_d;
  logic [23:0] tc_q, tc_d;

  logic        hdr_done, hdr_drop, label_end, name_term, name_bad, tail_done, qmatch;
  logic [15:0] q_dec;
  logic [7:0]  lc_byte;

  assign hdr_done  = (hdr_pos_q == mqr_pkg::HDR_LAST_POS);
  assign hdr_drop  = flags_q[7] | (|flags_q[6:3]) | (qcount_q == 16'd0);
  assign label_end = (label_left_q == 6'd0);
  assign name_term = label_end && (byte_i == 8'h00);
  assign name_bad  = label_end && (byte_i != 8'h00) && (|byte_i[7:6]);
  assign tail_done = (tail_pos_q == 2'd3);
  assign qmatch    = ({tc_q[6:0], byte_i} == mqr_pkg::QCLASS_IN) &&
                     ((tc_q[23:8] == mqr_pkg::QTYPE_A) ||
                      (tc_q[23:8] == mqr_pkg::QTYPE_ANY)) && name_ok_q;
  assign q_dec     = qcount_q - 16'd1;
  assign lc_byte   = ((byte_i >= mqr_pkg::ASCII_UPPER_A) &&
                      (byte_i <= mqr_pkg::ASCII_UPPER_Z)) ?
                     (byte_i + mqr_pkg::ASCII_CASE) : byte_i;

  // Next phase
  always_comb begin
    phase_d = phase_q;
    if (accept_i) begin
      unique case (phase_q)
        mqr_pkg::PH_HEADER: begin
          if (hdr_done) phase_d = hdr_drop ? mqr_pkg::PH_IGNORE : mqr_pkg::PH_NAME;
        end
        mqr_pkg::PH_NAME: begin
          if (name_term)     phase_d = mqr_pkg::PH_TAIL;
          else if (name_bad) phase_d = mqr_pkg::PH_IGNORE;
        end
        mqr_pkg::PH_TAIL: begin
          if (tail_done) begin
            if (qmatch || (q_dec == 16'd0)) phase_d = mqr_pkg::PH_IGNORE;
            else                            phase_d = mqr_pkg::PH_NAME;
          end
        end
        mqr_pkg::PH_IGNORE: phase_d = mqr_pkg::PH_IGNORE;
        default:            phase_d = mqr_pkg::PH_HEADER;
      endcase
      if (last_i) phase_d = mqr_pkg::PH_HEADER;
    end
  end

  // Datapath and match pulse
  always_comb begin
    hdr_pos_d    = hdr_pos_q;
    flags_d      = flags_q;
    qcount_d     = qcount_q;
    label_left_d = label_left_q;
    name_pos_d   = name_pos_q;
    name_ok_d    = name_ok_q;
    tail_pos_d   = tail_pos_q;
    tc_d         = tc_q;
    match_o      = 1'b0;
    if (accept_i) begin
      unique case (phase_q)
        mqr_pkg::PH_HEADER: begin
          if (hdr_pos_q == mqr_pkg::HDR_FLAGS_POS) flags_d = byte_i;
          else if (hdr_pos_q == mqr_pkg::HDR_QDHI_POS) qcount_d = {byte_i, 8'h00};
          else if (hdr_pos_q == mqr_pkg::HDR_QDLO_POS) qcount_d = {qcount_q[15:8], byte_i};
          if (!hdr_done) begin
            hdr_pos_d = hdr_pos_q + 4'd1;
          end else if (!hdr_drop) begin
            label_left_d = '0;
            name_pos_d   = '0;
            name_ok_d    = 1'b1;
            tail_pos_d   = '0;
            tc_d         = '0;
          end
        end
        mqr_pkg::PH_NAME: begin
          if (name_pos_q >= mqr_pkg::NAME_POS_W'(mqr_pkg::HOST_NAME_LEN)) begin
            name_ok_d = 1'b0;
          end else begin
            if (lc_byte != mqr_pkg::HOST_NAME[name_pos_q]) name_ok_d = 1'b0;
            name_pos_d = name_pos_q + mqr_pkg::NAME_POS_W'(1);
          end
          if (!label_end) begin
            label_left_d = label_left_q - 6'd1;
          end else if (name_term) begin
            tail_pos_d = '0;
            tc_d       = '0;
          end else if (!name_bad) begin
            label_left_d = byte_i[5:0];
          end
        end
        mqr_pkg::PH_TAIL: begin
          if (!tail_done) begin
            tc_d       = {tc_q[15:0], byte_i};
            tail_pos_d = tail_pos_q + 2'd1;
          end else if (qmatch) begin
            match_o = 1'b1;
          end else begin
            qcount_d = q_dec;
            if (q_dec != 16'd0) begin
              label_left_d = '0;
              name_pos_d   = '0;
              name_ok_d    = 1'b1;
              tail_pos_d   = '0;
              tc_d         = '0;
            end
          end
        end
        mqr_pkg::PH_IGNORE: ;
        default: ;
      endcase
      if (last_i) begin
        hdr_pos_d    = '0;
        flags_d      = '0;
        qcount_d     = '0;
        label_left_d = '0;
        name_pos_d   = '0;
        name_ok_d    = 1'b1;
        tail_pos_d   = '0;
        tc_d         = '0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= mqr_pkg::PH_HEADER;
      hdr_pos_q    <= '0;
      flags_q      <= '0;
      qcount_q     <= '0;
      label_left_q <= '0;
      name_pos_q   <= '0;
      name_ok_q    <= 1'b1;
      tail_pos_q   <= '0;
      tc_q         <= '0;
    end else begin
      phase_q      <= phase_d;
      hdr_pos_q    <= hdr_pos_d;
      flags_q      <= flags_d;
      qcount_q     <= qcount_d;
      label_left_q <= label_left_d;
      name_pos_q   <= name_pos_d;
      name_ok_q    <= name_ok_d;
      tail_pos_q   <= tail_pos_d;
      tc_q         <= tc_d;
    end
  end

endmodule

/* design/mqr_answer_gen.sv */
// Answer burst generator: byte counter and registered output stage.
// Depends on mqr_pkg for the answer byte table.
module mqr_answer_gen (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] ipv4_i,
  input  logic        ready_i,
  output logic        valid_o,
  output logic [7:0]  data_o,
  output logic        last_o
);

  logic                          busy_q, busy_d;
  logic [mqr_pkg::ANS_IDX_W-1:0] idx_q, idx_d;
  logic [7:0]                    data_q, data_d;
  logic                          last_q, last_d;
  logic [mqr_pkg::ANS_IDX_W-1:0] idx_nxt;

  assign idx_nxt = idx_q + mqr_pkg::ANS_IDX_W'(1);

  always_comb begin
    busy_d = busy_q;
    idx_d  = idx_q;
    data_d = data_q;
    last_d = last_q;
    if (start_i) begin
      busy_d = 1'b1;
      idx_d  = '0;
      data_d = mqr_pkg::answer_byte('0, ipv4_i);
      last_d = 1'b0;
    end else if (busy_q && ready_i) begin
      if (last_q) begin
        busy_d = 1'b0;
      end else begin
        idx_d  = idx_nxt;
        data_d = mqr_pkg::answer_byte(idx_nxt, ipv4_i);
        last_d = (idx_nxt == mqr_pkg::ANS_LAST_IDX);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      idx_q  <= '0;
      last_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      idx_q  <= idx_d;
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    data_q <= data_d;
  end

  assign valid_o = busy_q;
  assign data_o  = data_q;
  assign last_o  = last_q;

endmodule

/* design/mdns_a_query_responder_unit.sv */
// Top level of the mDNS A query responder: stream ports, address register, assertions.
// Depends on mqr_pkg, mqr_parser and mqr_answer_gen.

// Takes a DNS payload one byte per request on the slave stream (tlast on the
// final byte) and, when a question asks for the A or ANY record of the local
// host name with class IN, sends a 38-byte answer on the master stream, one
// byte per request, tlast on the last byte. Input bytes are accepted every
// cycle, except while an answer burst is under way: s_axis_tready is low from
// the cycle after the matching byte until the last answer byte is taken. The
// first answer byte is valid in the cycle after the byte that completes the
// matching question. Malformed, truncated, response or non-matching payloads
// give no output. cfg_data_i (host_ipv4, first octet in bits 31:24) is
// written whenever cfg_valid_i is high; change it only while no answer is
// pending.
module mdns_a_query_responder_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Payload in
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] in_byte
  input  logic        s_axis_tlast,   // in_last
  // Answer out
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [7:0]  m_axis_tdata,   // [7:0] out_byte
  output logic        m_axis_tlast,   // out_last
  // host_ipv4 register write
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [31:0] cfg_data_i
);

  logic [31:0] ipv4_q;
  logic        in_accept;
  logic        ans_start;

  // Burst in progress blocks new payload bytes.
  assign s_axis_tready = !m_axis_tvalid;
  assign in_accept     = s_axis_tvalid && s_axis_tready;
  assign cfg_ready_o   = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ipv4_q <= '0;
    end else if (cfg_valid_i) begin
      ipv4_q <= cfg_data_i;
    end
  end

  mqr_parser u_parser (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (in_accept),
    .byte_i   (s_axis_tdata),
    .last_i   (s_axis_tlast),
    .match_o  (ans_start)
  );

  mqr_answer_gen u_answer (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (ans_start),
    .ipv4_i  (ipv4_q),
    .ready_i (m_axis_tready),
    .valid_o (m_axis_tvalid),
    .data_o  (m_axis_tdata),
    .last_o  (m_axis_tlast)
  );

`ifndef ASSERT_OFF
  // A match can only come from an accepted byte, never during a burst.
  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ans_start |-> (in_accept && !m_axis_tvalid))
    else $error("answer start while burst active");

  // A match opens a burst whose first byte is the zero ID byte, not last.
  a_start_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ans_start |=> (m_axis_tvalid && (m_axis_tdata == 8'h00) && !m_axis_tlast))
    else $error("burst did not open correctly");

  // Taking the last answer byte ends the burst and reopens the input.
  a_burst_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tready && m_axis_tlast) |=> (!m_axis_tvalid && s_axis_tready))
    else $error("burst did not end after last byte");
`endif

endmodule
